FILE: src/cnws_pkg.sv
// Package for the character LCD nibble write sequencer.
// Holds request codes, register indexes, the control word format and the
// microcode program. No dependencies.
package cnws_pkg;

	localparam int WAIT_W  = 20;
	localparam int STB_W   = 8;
	localparam int CFG_IDX_W = 3;

	// Request codes
	typedef enum logic [1:0] {
		REQ_CMD  = 2'd0,
		REQ_DATA = 2'd1,
		REQ_INIT = 2'd2
	} req_type_t;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POWERUP_WAIT = 3'd0,
		CFG_FIRST_WAIT   = 3'd1,
		CFG_STEP_WAIT    = 3'd2,
		CFG_SHORT_WAIT   = 3'd3,
		CFG_LONG_WAIT    = 3'd4,
		CFG_STROBE_WIDTH = 3'd5
	} cfg_idx_t;

	// Register reset values
	localparam logic [WAIT_W-1:0] RST_POWERUP_WAIT = 20'd200000;
	localparam logic [WAIT_W-1:0] RST_FIRST_WAIT   = 20'd50000;
	localparam logic [WAIT_W-1:0] RST_STEP_WAIT    = 20'd10000;
	localparam logic [WAIT_W-1:0] RST_SHORT_WAIT   = 20'd500;
	localparam logic [WAIT_W-1:0] RST_LONG_WAIT    = 20'd20000;
	localparam logic [STB_W-1:0]  RST_STROBE_WIDTH = 8'd10;

	// Wait registers handed to the engine
	typedef struct packed {
		logic [WAIT_W-1:0] powerup;
		logic [WAIT_W-1:0] first;
		logic [WAIT_W-1:0] step;
		logic [WAIT_W-1:0] short_w;
		logic [WAIT_W-1:0] long_w;
	} cnws_waits_t;

	// Control word fields
	typedef enum logic [1:0] {
		NIB_IMM = 2'd0,
		NIB_HI  = 2'd1,
		NIB_LO  = 2'd2
	} nib_sel_t;

	typedef enum logic [2:0] {
		W_ZERO    = 3'd0,
		W_POWERUP = 3'd1,
		W_FIRST   = 3'd2,
		W_STEP    = 3'd3,
		W_SHORT   = 3'd4,
		W_LONG    = 3'd5,
		W_BYTE    = 3'd6
	} wait_sel_t;

	typedef struct packed {
		nib_sel_t   nib_sel;
		logic [3:0] imm;
		logic       strobe;
		wait_sel_t  wait_sel;
		logic       last;
	} ucode_t;

	// Program layout
	localparam int UC_LEN = 17;
	localparam int PC_W   = $clog2(UC_LEN);
	localparam logic [PC_W-1:0] UC_BYTE = PC_W'(0);
	localparam logic [PC_W-1:0] UC_INIT = PC_W'(2);

	// Fixed init commands
	localparam logic [7:0] CMD_FUNC_SET = 8'h2E;
	localparam logic [7:0] CMD_DISP_OFF = 8'h08;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;

	function automatic ucode_t uc_word(nib_sel_t sel, logic [3:0] imm, logic stb,
			wait_sel_t ws, logic last);
		ucode_t w;
		w.nib_sel  = sel;
		w.imm      = imm;
		w.strobe   = stb;
		w.wait_sel = ws;
		w.last     = last;
		return w;
	endfunction

	// One half of a fixed command; a command with either of its low two bits set (clear/home style) gets the long wait
	function automatic ucode_t uc_cmd(logic [7:0] cmd, logic lo, logic last);
		wait_sel_t ws;
		ws = (cmd[1:0] != 2'b00) ? W_LONG : W_SHORT;
		if (lo)
			return uc_word(NIB_IMM, cmd[3:0], 1'b1, ws, last);
		return uc_word(NIB_IMM, cmd[7:4], 1'b1, W_ZERO, 1'b0);
	endfunction

	// Microcode program
	function automatic ucode_t ucode_rom(logic [PC_W-1:0] addr);
		case (addr)
			PC_W'(0):  return uc_word(NIB_HI, 4'h0, 1'b1, W_ZERO, 1'b0);
			PC_W'(1):  return uc_word(NIB_LO, 4'h0, 1'b1, W_BYTE, 1'b1);
			PC_W'(2):  return uc_word(NIB_IMM, 4'h0, 1'b0, W_POWERUP, 1'b0);
			PC_W'(3):  return uc_word(NIB_IMM, 4'h3, 1'b1, W_FIRST, 1'b0);
			PC_W'(4):  return uc_word(NIB_IMM, 4'h3, 1'b1, W_STEP, 1'b0);
			PC_W'(5):  return uc_word(NIB_IMM, 4'h3, 1'b1, W_STEP, 1'b0);
			PC_W'(6):  return uc_word(NIB_IMM, 4'h2, 1'b1, W_STEP, 1'b0);
			PC_W'(7):  return uc_cmd(CMD_FUNC_SET, 1'b0, 1'b0);
			PC_W'(8):  return uc_cmd(CMD_FUNC_SET, 1'b1, 1'b0);
			PC_W'(9):  return uc_cmd(CMD_DISP_OFF, 1'b0, 1'b0);
			PC_W'(10): return uc_cmd(CMD_DISP_OFF, 1'b1, 1'b0);
			PC_W'(11): return uc_cmd(CMD_DISP_ON, 1'b0, 1'b0);
			PC_W'(12): return uc_cmd(CMD_DISP_ON, 1'b1, 1'b0);
			PC_W'(13): return uc_cmd(CMD_ENTRY, 1'b0, 1'b0);
			PC_W'(14): return uc_cmd(CMD_ENTRY, 1'b1, 1'b0);
			PC_W'(15): return uc_cmd(CMD_CLEAR, 1'b0, 1'b0);
			PC_W'(16): return uc_cmd(CMD_CLEAR, 1'b1, 1'b1);
			default:   return uc_word(NIB_IMM, 4'h0, 1'b0, W_ZERO, 1'b1);
		endcase
	endfunction

endpackage

FILE: src/cnws_if.sv
// Channel interfaces for the LCD nibble write sequencer: request, bus event
// and configuration write. Depends on cnws_pkg.
interface cnws_req_if import cnws_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] byte_value;

	modport source (output valid, req_type, byte_value, input ready);
	modport sink   (input valid, req_type, byte_value, output ready);
endinterface

interface cnws_evt_if import cnws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [3:0]        nibble;
	logic              reg_select;
	logic              strobe_res;
	logic [WAIT_W-1:0] wait_after;
	logic              last;

	modport source (output valid, nibble, reg_select, strobe_res, wait_after, last,
		input ready);
	modport sink   (input valid, nibble, reg_select, strobe_res, wait_after, last,
		output ready);
endinterface

interface cnws_cfg_if import cnws_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WAIT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/cnws_engine.sv
// Microcoded sequencer: step counter, control word decode, nibble/wait
// datapath and the output event register. Depends on cnws_pkg, cnws_if.
module cnws_engine import cnws_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cnws_req_if.sink      req,
	cnws_evt_if.source    evt,
	input  cnws_waits_t   waits
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [7:0]      byte_q;
	logic            is_data_q;
	logic            out_valid_q;
	logic [3:0]      nibble_q;
	logic            rs_q;
	logic            strobe_q;
	logic [WAIT_W-1:0] wait_q;
	logic            last_q;

	ucode_t            uw;
	logic              adv;
	logic              req_acc;
	logic [3:0]        nib_d;
	logic [WAIT_W-1:0] wait_d;

	assign req.ready = !busy_q;
	assign req_acc   = req.valid && !busy_q;
	assign adv       = busy_q && (!out_valid_q || evt.ready);

	// Control word for the current step
	assign uw = ucode_rom(pc_q);

	// Nibble select
	always_comb begin
		case (uw.nib_sel)
			NIB_HI:  nib_d = byte_q[7:4];
			NIB_LO:  nib_d = byte_q[3:0];
			default: nib_d = uw.imm;
		endcase
	end

	// Wait select
	always_comb begin
		case (uw.wait_sel)
			W_POWERUP: wait_d = waits.powerup;
			W_FIRST:   wait_d = waits.first;
			W_STEP:    wait_d = waits.step;
			W_SHORT:   wait_d = waits.short_w;
			W_LONG:    wait_d = waits.long_w;
			W_BYTE: begin
				if (!is_data_q && byte_q[1:0] != 2'b00)
					wait_d = waits.long_w;
				else
					wait_d = waits.short_w;
			end
			default:   wait_d = '0;
		endcase
	end

	// Step counter and request latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= UC_BYTE;
		end else if (req_acc) begin
			case (req.req_type)
				REQ_CMD, REQ_DATA: begin
					busy_q <= 1'b1;
					pc_q   <= UC_BYTE;
				end
				REQ_INIT: begin
					busy_q <= 1'b1;
					pc_q   <= UC_INIT;
				end
				default: busy_q <= 1'b0;
			endcase
		end else if (adv) begin
			if (uw.last)
				busy_q <= 1'b0;
			else
				pc_q <= pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			byte_q    <= req.byte_value;
			is_data_q <= (req.req_type == REQ_DATA);
		end
	end

	// Output event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (evt.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nibble_q <= uw.strobe ? nib_d : 4'h0;
			rs_q     <= uw.strobe ? is_data_q : 1'b0;
			strobe_q <= uw.strobe;
			wait_q   <= wait_d;
			last_q   <= uw.last;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.nibble     = nibble_q;
	assign evt.reg_select = rs_q;
	assign evt.strobe_res = strobe_q;
	assign evt.wait_after = wait_q;
	assign evt.last       = last_q;

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && uw.last |=> !busy_q)
		else $error("sequencer still busy after final event");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q < PC_W'(UC_LEN))
		else $error("step counter beyond program");
	a_init_entry: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.req_type == REQ_INIT |=> busy_q && pc_q == UC_INIT)
		else $error("init request did not enter init program");
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> busy_q)
		else $error("non-final event pending with sequencer idle");
`endif

endmodule

FILE: src/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD nibble write sequencer: configuration
// registers and channel wiring. Depends on cnws_pkg, cnws_if, cnws_engine.
//
// Usage:
//  - req channel: one transaction is a request (command write, data write or
//    power-up init). Request code 3 is accepted and dropped with no events.
//  - evt channel: one transaction per bus event (nibble, register select,
//    strobe flag, wait after, last marker). last closes each command, data or init request.
//  - cfg channel: always ready; writes wait and strobe-width registers by
//    index. Indexes beyond the list are ignored. Write only while idle.
//  - A taken request loads the step counter; each event then passes through
//    the output event register, one event per cycle while the receiver takes
//    them. A command or data write runs the byte program, init the
//    fifteen-step init program; no new request is taken while busy.
//  - The next request is taken while the final event still sits in the
//    output register. A stalled receiver holds the event and the counter.
//  - Reset: asynchronous, active low; registers return to their defaults and
//    the channels come up empty.
module char_lcd_nibble_write_sequencer import cnws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cnws_req_if.sink    req,
	cnws_evt_if.source  evt,
	cnws_cfg_if.sink    cfg
);

	cnws_waits_t      waits_q;
	logic [STB_W-1:0] strobe_width_q;
	logic             cfg_acc;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waits_q.powerup <= RST_POWERUP_WAIT;
			waits_q.first   <= RST_FIRST_WAIT;
			waits_q.step    <= RST_STEP_WAIT;
			waits_q.short_w <= RST_SHORT_WAIT;
			waits_q.long_w  <= RST_LONG_WAIT;
			strobe_width_q  <= RST_STROBE_WIDTH;
		end else if (cfg_acc) begin
			case (cfg.index)
				CFG_POWERUP_WAIT: waits_q.powerup <= cfg.data;
				CFG_FIRST_WAIT:   waits_q.first   <= cfg.data;
				CFG_STEP_WAIT:    waits_q.step    <= cfg.data;
				CFG_SHORT_WAIT:   waits_q.short_w <= cfg.data;
				CFG_LONG_WAIT:    waits_q.long_w  <= cfg.data;
				CFG_STROBE_WIDTH: strobe_width_q  <= cfg.data[STB_W-1:0];
				default: ;
			endcase
		end
	end

	cnws_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.evt    (evt),
		.waits  (waits_q)
	);

`ifndef SYNTHESIS
	a_strobe_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc && cfg.index == CFG_STROBE_WIDTH |=>
		strobe_width_q == $past(cfg.data[STB_W-1:0]))
		else $error("strobe width write lost");
	a_powerup_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc && cfg.index == CFG_POWERUP_WAIT |=> waits_q.powerup == $past(cfg.data))
		else $error("power-up wait write lost");
	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc && cfg.index > CFG_STROBE_WIDTH |=>
		$stable(waits_q) && $stable(strobe_width_q))
		else $error("write beyond register list changed a register");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the character LCD nibble write sequencer.
// Drives requests and register writes, predicts every bus event and checks
// each one as it is taken. Depends on cnws_pkg, cnws_if and the RTL top.
module testbench import cnws_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Request code with no operation behind it
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Register indexes past the end of the list
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} lcd_req_t;

	typedef struct packed {
		logic [3:0]        nibble;
		logic              reg_select;
		logic              strobe_res;
		logic [WAIT_W-1:0] wait_after;
		logic              last;
	} bus_event_t;

	logic clk = 1'b0;
	logic arst_n;

	cnws_req_if req_ch ();
	cnws_evt_if evt_ch ();
	cnws_cfg_if cfg_ch ();

	char_lcd_nibble_write_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.evt    (evt_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Bench copy of the timing registers
	logic [WAIT_W-1:0] powerup_w, first_w, step_w, short_w, long_w;
	logic [STB_W-1:0]  strobe_w;

	lcd_req_t   pending_reqs[$];
	bus_event_t bus_events_due[$];
	lcd_req_t   next_req;
	bus_event_t due_evt;
	int         errors = 0;
	int         src_idle_pct = 0;
	int         snk_idle_pct = 0;
	bit         hold_on = 1'b0;
	int         hold_count;

	function automatic void push_event(logic [3:0] nib, logic rs, logic stb,
			logic [WAIT_W-1:0] w, logic last);
		bus_event_t e;
		e.nibble     = nib;
		e.reg_select = rs;
		e.strobe_res = stb;
		e.wait_after = w;
		e.last       = last;
		bus_events_due.push_back(e);
	endfunction

	// High nibble then low nibble; the wait goes on the low one
	function automatic void push_byte_events(logic [7:0] b, logic is_data, logic last);
		logic [WAIT_W-1:0] w;
		w = (is_data || b[1:0] == 2'b00) ? short_w : long_w;
		push_event(b[7:4], is_data, 1'b1, '0, 1'b0);
		push_event(b[3:0], is_data, 1'b1, w, last);
	endfunction

	// Bus events caused by one accepted request
	function automatic void predict_bus_events(logic [1:0] kind, logic [7:0] b);
		case (kind)
			REQ_CMD:  push_byte_events(b, 1'b0, 1'b1);
			REQ_DATA: push_byte_events(b, 1'b1, 1'b1);
			REQ_INIT: begin
				push_event(4'h0, 1'b0, 1'b0, powerup_w, 1'b0);
				push_event(4'h3, 1'b0, 1'b1, first_w, 1'b0);
				push_event(4'h3, 1'b0, 1'b1, step_w, 1'b0);
				push_event(4'h3, 1'b0, 1'b1, step_w, 1'b0);
				push_event(4'h2, 1'b0, 1'b1, step_w, 1'b0);
				push_byte_events(CMD_FUNC_SET, 1'b0, 1'b0);
				push_byte_events(CMD_DISP_OFF, 1'b0, 1'b0);
				push_byte_events(CMD_DISP_ON, 1'b0, 1'b0);
				push_byte_events(CMD_ENTRY, 1'b0, 1'b0);
				push_byte_events(CMD_CLEAR, 1'b0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// Request driver: predicts on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.req_type   <= '0;
			req_ch.byte_value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_bus_events(req_ch.req_type, req_ch.byte_value);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_req = pending_reqs.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.req_type   <= next_req.kind;
					req_ch.byte_value <= next_req.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Event receiver: random stalls, plus one long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.ready <= 1'b0;
			hold_count   <= 0;
		end else if (hold_on && hold_count < HOLD_CYCLES) begin
			evt_ch.ready <= 1'b0;
			hold_count   <= hold_count + 1;
		end else begin
			evt_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Event monitor
	always @(posedge clk) begin
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (bus_events_due.size() == 0) begin
				$error("unexpected bus event: nibble %0h rs %0b", evt_ch.nibble,
					evt_ch.reg_select);
				errors++;
			end else begin
				due_evt = bus_events_due.pop_front();
				if (evt_ch.nibble !== due_evt.nibble) begin
					$error("nibble: expected %0h, got %0h", due_evt.nibble, evt_ch.nibble);
					errors++;
				end
				if (evt_ch.reg_select !== due_evt.reg_select) begin
					$error("reg_select: expected %0b, got %0b", due_evt.reg_select,
						evt_ch.reg_select);
					errors++;
				end
				if (evt_ch.strobe_res !== due_evt.strobe_res) begin
					$error("strobe_res: expected %0b, got %0b", due_evt.strobe_res,
						evt_ch.strobe_res);
					errors++;
				end
				if (evt_ch.wait_after !== due_evt.wait_after) begin
					$error("wait_after: expected %0d, got %0d", due_evt.wait_after,
						evt_ch.wait_after);
					errors++;
				end
				if (evt_ch.last !== due_evt.last) begin
					$error("last: expected %0b, got %0b", due_evt.last, evt_ch.last);
					errors++;
				end
			end
		end
	end

	task automatic add_request(logic [1:0] kind, logic [7:0] value);
		lcd_req_t r;
		r.kind  = kind;
		r.value = value;
		pending_reqs.push_back(r);
	endtask

	// Mostly writes, some init, a few unused codes
	task automatic add_random_requests(int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 40)
				add_request(REQ_CMD, 8'($urandom_range(255)));
			else if (pick < 75)
				add_request(REQ_DATA, 8'($urandom_range(255)));
			else if (pick < 90)
				add_request(REQ_INIT, 8'($urandom_range(255)));
			else
				add_request(REQ_UNUSED, 8'($urandom_range(255)));
		end
	endtask

	// One register write transaction; bench copy follows on acceptance
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WAIT_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_POWERUP_WAIT: powerup_w = val;
			CFG_FIRST_WAIT:   first_w   = val;
			CFG_STEP_WAIT:    step_w    = val;
			CFG_SHORT_WAIT:   short_w   = val;
			CFG_LONG_WAIT:    long_w    = val;
			CFG_STROBE_WIDTH: strobe_w  = val[STB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(logic [WAIT_W-1:0] p, logic [WAIT_W-1:0] f,
			logic [WAIT_W-1:0] s, logic [WAIT_W-1:0] sh, logic [WAIT_W-1:0] l,
			logic [STB_W-1:0] stb);
		write_reg(CFG_POWERUP_WAIT, p);
		write_reg(CFG_FIRST_WAIT, f);
		write_reg(CFG_STEP_WAIT, s);
		write_reg(CFG_SHORT_WAIT, sh);
		write_reg(CFG_LONG_WAIT, l);
		write_reg(CFG_STROBE_WIDTH, WAIT_W'(stb));
	endtask

	// Everything sent and every event seen, then let an unused code settle
	task automatic drain();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || bus_events_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Main sequence
	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = '0;
		req_ch.byte_value = '0;
		evt_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		powerup_w = RST_POWERUP_WAIT;
		first_w   = RST_FIRST_WAIT;
		step_w    = RST_STEP_WAIT;
		short_w   = RST_SHORT_WAIT;
		long_w    = RST_LONG_WAIT;
		strobe_w  = RST_STROBE_WIDTH;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset timing: byte extremes, long-wait low bits, unused code
		src_idle_pct = 27;
		snk_idle_pct = 74;
		add_request(REQ_CMD, 8'h00);
		add_request(REQ_CMD, 8'hFF);
		add_request(REQ_CMD, 8'h01);
		add_request(REQ_CMD, 8'h02);
		add_request(REQ_CMD, 8'h03);
		add_request(REQ_CMD, 8'h04);
		add_request(REQ_CMD, 8'h0C);
		add_request(REQ_DATA, 8'h00);
		add_request(REQ_DATA, 8'hFF);
		add_request(REQ_DATA, 8'h03);
		add_request(REQ_DATA, 8'hA5);
		add_request(REQ_INIT, 8'h00);
		add_request(REQ_UNUSED, 8'hFF);
		add_request(REQ_INIT, 8'hFF);
		add_request(REQ_UNUSED, 8'h00);
		add_request(REQ_DATA, 8'h5A);
		add_request(REQ_CMD, 8'h80);
		add_request(REQ_UNUSED, 8'h3C);
		drain();

		// All-ones timing; spare indexes must be ignored
		set_timing('1, '1, '1, '1, '1, 8'hFF);
		write_reg(CFG_SPARE_LO, WAIT_W'($urandom_range(20'hFFFFF)));
		write_reg(CFG_SPARE_HI, '1);
		add_request(REQ_INIT, 8'h00);
		add_random_requests(27);
		drain();

		// Zero waits, narrowest strobe, idling swapped
		src_idle_pct = 74;
		snk_idle_pct = 27;
		set_timing('0, '0, '0, '0, '0, 8'd1);
		write_reg(CFG_SPARE_HI, '0);
		add_request(REQ_INIT, 8'h00);
		add_random_requests(27);
		drain();

		// Random timing, no idling, receiver held off to back the block up
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_timing(WAIT_W'($urandom_range(20'hFFFFF)), WAIT_W'($urandom_range(20'hFFFFF)),
			WAIT_W'($urandom_range(20'hFFFFF)), WAIT_W'($urandom_range(20'hFFFFF)),
			WAIT_W'($urandom_range(20'hFFFFF)), STB_W'($urandom_range(1, 255)));
		hold_on = 1'b1;
		add_random_requests(28);
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/cnws_pkg.sv
src/cnws_if.sv
src/cnws_engine.sv
src/char_lcd_nibble_write_sequencer.sv
bench/testbench.sv
